@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SCSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define SCSC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ sv/scsc_pkg.sv @@
// ----------------------------------------------------------------------------
// scsc_pkg
// Types and constants shared by the score cache modules.
// ----------------------------------------------------------------------------
package scsc_pkg;

	localparam int SLOTS        = 1024;
	localparam int PAYLOAD_BITS = 32;
	localparam int IDX_W        = $clog2(SLOTS);
	localparam int CNT_W        = 11;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	// Request codes.
	localparam logic [1:0] REQ_GET   = 2'd0;
	localparam logic [1:0] REQ_SET   = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// Limit after reset and the sweep target that goes with it.
	localparam int MAX_RESET = 1024;
	localparam logic [CNT_W-1:0] MAX_RESET_V    = CNT_W'(MAX_RESET);
	localparam logic [CNT_W-1:0] TARGET_RESET_V = CNT_W'((2 * MAX_RESET) / 3 + 1);

	// Division by three of a 12-bit value: (x * 2731) >> 13 is exact below 4096.
	localparam int DIV3_IN_W  = CNT_W + 1;
	localparam int DIV3_SHIFT = 13;
	localparam logic [DIV3_IN_W-1:0] DIV3_MUL = DIV3_IN_W'(2731);

	typedef struct packed {
		logic                    valid;
		logic                    referenced;
		logic [PAYLOAD_BITS-1:0] payload;
	} entry_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
	} mem_req_t;

	typedef struct packed {
		logic [CNT_W-1:0] max_entries;
		logic [CNT_W-1:0] target;
	} limits_t;

endpackage

@@ sv/second_chance_score_cache.sv @@
// ----------------------------------------------------------------------------
// second_chance_score_cache
// Directly indexed handle cache with second-chance eviction.
// ----------------------------------------------------------------------------
// Usage:
// A request enters on the in_valid/in_ready channel with req_type, slot_index
// and payload_in; every request returns exactly one result on the
// out_valid/out_ready channel (hit, payload_out, occupancy, evicted).
// The occupancy limit is written on the cfg_valid/cfg_ready/cfg_data channel,
// which is always ready; write it only while no request is in flight.
// A get or a set is one read and one write-back of the slot memory: the result
// is registered in the lookup step once the output register is free, and the
// next request is taken only once the block is back in its idle state.
// A set on an empty slot with the cache at its limit first runs an eviction
// sweep that walks the slot memory one entry per cycle, in one or two passes,
// before its result is given.
// A clear rewrites all 1024 entries, one per cycle, then returns its result.
// After reset the same clearing pass runs with in_ready low.
// The result sits in an output register; a stalled receiver lets the next
// request be taken, which then waits in its last step until the output frees.
// ----------------------------------------------------------------------------
module second_chance_score_cache
	import scsc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              req_type,
	input  logic [IDX_W-1:0]        slot_index,
	input  logic [PAYLOAD_BITS-1:0] payload_in,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    hit,
	output logic [PAYLOAD_BITS-1:0] payload_out,
	output logic [CNT_W-1:0]        occupancy,
	output logic [CNT_W-1:0]        evicted,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CNT_W-1:0]        cfg_data
);

	limits_t  lim;
	mem_req_t mem_req;
	entry_t   rd_data;

	// The limit register also keeps the sweep target so the sweep compare is
	// a plain register-to-register compare.
	scsc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.lim       (lim)
	);

	// Valid bit, referenced bit and handle of every slot live in one word.
	scsc_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	// The sequencer never reads and writes the same entry in one cycle, and a
	// write-back always lands before the next request's read, so no forwarding
	// is needed.
	scsc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.slot_index  (slot_index),
		.payload_in  (payload_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hit         (hit),
		.payload_out (payload_out),
		.occupancy   (occupancy),
		.evicted     (evicted),
		.lim         (lim),
		.mem_req     (mem_req),
		.rd_data     (rd_data)
	);

endmodule

@@ sv/scsc_mem.sv @@
// ----------------------------------------------------------------------------
// scsc_mem
// Slot memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module scsc_mem
	import scsc_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output entry_t   rd_data
);

	entry_t mem_q [SLOTS];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ sv/scsc_cfg.sv @@
// ----------------------------------------------------------------------------
// scsc_cfg
// Occupancy limit register and the sweep target derived from it.
// ----------------------------------------------------------------------------
module scsc_cfg
	import scsc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data,
	output limits_t          lim
);

	logic [DIV3_IN_W-1:0]   twice;
	logic [2*DIV3_IN_W-1:0] prod;
	logic [CNT_W-1:0]       target;
	logic [CNT_W-1:0]       max_q;
	logic [CNT_W-1:0]       target_q;

	// The target is two thirds of the limit, rounded down, plus one.
	assign twice  = {cfg_data, 1'b0};
	assign prod   = twice * DIV3_MUL;
	assign target = prod[DIV3_SHIFT +: CNT_W] + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q    <= MAX_RESET_V;
			target_q <= TARGET_RESET_V;
		end else if (cfg_valid) begin
			max_q    <= cfg_data;
			target_q <= target;
		end
	end

	assign cfg_ready       = 1'b1;
	assign lim.max_entries = max_q;
	assign lim.target      = target_q;

endmodule

@@ sv/scsc_ctrl.sv @@
// ----------------------------------------------------------------------------
// scsc_ctrl
// Request sequencer: lookup, read-modify-write, eviction sweep and clearing.
// ----------------------------------------------------------------------------
module scsc_ctrl
	import scsc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              req_type,
	input  logic [IDX_W-1:0]        slot_index,
	input  logic [PAYLOAD_BITS-1:0] payload_in,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    hit,
	output logic [PAYLOAD_BITS-1:0] payload_out,
	output logic [CNT_W-1:0]        occupancy,
	output logic [CNT_W-1:0]        evicted,
	input  limits_t                 lim,
	output mem_req_t                mem_req,
	input  entry_t                  rd_data
);

	typedef enum logic [2:0] {
		S_WIPE,
		S_IDLE,
		S_LOOK,
		S_SWEEP,
		S_COMMIT
	} state_t;

	state_t                  state_q;
	logic [1:0]              op_q;
	logic [IDX_W-1:0]        slot_q;
	logic [PAYLOAD_BITS-1:0] pl_q;
	logic [IDX_W-1:0]        ptr_q;
	logic                    rd_last_q;
	logic                    pass2_q;
	logic                    wipe_resp_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        ev_q;
	logic                    proc_v_s1;
	logic [IDX_W-1:0]        proc_idx_s1;
	logic                    out_valid_q;
	logic                    hit_q;
	logic [PAYLOAD_BITS-1:0] payload_q;
	logic [CNT_W-1:0]        occ_q;
	logic [CNT_W-1:0]        ev_out_q;

	logic   out_free;
	logic   out_load;
	logic   full;
	logic   over;
	logic   free_slot;
	logic   pass_end;
	logic   lk_store;
	logic   lk_sweep;
	entry_t stored;

	assign out_free  = !out_valid_q || out_ready;
	assign full      = count_q >= lim.max_entries;
	assign over      = count_q > lim.target;
	assign free_slot = proc_v_s1 && rd_data.valid && (pass2_q || !rd_data.referenced);
	assign pass_end  = proc_v_s1 && (proc_idx_s1 == LAST_IDX);
	assign lk_store  = (op_q == REQ_SET) && (rd_data.valid || !full);
	assign lk_sweep  = (op_q == REQ_SET) && !rd_data.valid && full;

	// The output register takes a new result in this cycle.
	assign out_load  = out_free && (((state_q == S_LOOK) && !lk_sweep) ||
		(state_q == S_COMMIT));

	assign stored.valid      = 1'b1;
	assign stored.referenced = 1'b1;
	assign stored.payload    = pl_q;

	always_comb begin
		mem_req = '0;
		unique case (state_q)
			S_IDLE: begin
				mem_req.rd_en   = in_valid;
				mem_req.rd_addr = slot_index;
			end
			S_WIPE: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = ptr_q;
			end
			S_LOOK: begin
				mem_req.wr_addr = slot_q;
				if (out_free && (op_q == REQ_GET)) begin
					mem_req.wr_en                   = 1'b1;
					mem_req.wr_data                 = rd_data;
					mem_req.wr_data.referenced      = 1'b1;
				end else if (out_free && lk_store) begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_data = stored;
				end
			end
			S_SWEEP: begin
				mem_req.rd_en                   = over && !pass_end && !rd_last_q;
				mem_req.rd_addr                 = ptr_q;
				mem_req.wr_en                   = over && proc_v_s1 && rd_data.valid;
				mem_req.wr_addr                 = proc_idx_s1;
				mem_req.wr_data.valid           = !free_slot;
				mem_req.wr_data.referenced      = 1'b0;
				mem_req.wr_data.payload         = rd_data.payload;
			end
			S_COMMIT: begin
				mem_req.wr_en   = out_free && (op_q == REQ_SET);
				mem_req.wr_addr = slot_q;
				mem_req.wr_data = stored;
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_WIPE;
			op_q        <= REQ_GET;
			slot_q      <= '0;
			pl_q        <= '0;
			ptr_q       <= '0;
			rd_last_q   <= 1'b0;
			pass2_q     <= 1'b0;
			wipe_resp_q <= 1'b0;
			count_q     <= '0;
			ev_q        <= '0;
			proc_v_s1   <= 1'b0;
			proc_idx_s1 <= '0;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			payload_q   <= '0;
			occ_q       <= '0;
			ev_out_q    <= '0;
		end else begin
			if (out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_WIPE: begin
					if (ptr_q == LAST_IDX) begin
						ptr_q   <= '0;
						state_q <= wipe_resp_q ? S_COMMIT : S_IDLE;
					end else begin
						ptr_q <= ptr_q + IDX_W'(1);
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						op_q   <= req_type;
						slot_q <= slot_index;
						pl_q   <= payload_in;
						if (req_type == REQ_CLEAR) begin
							state_q     <= S_WIPE;
							ptr_q       <= '0;
							wipe_resp_q <= 1'b1;
							count_q     <= '0;
						end else begin
							state_q <= S_LOOK;
						end
					end
				end
				S_LOOK: begin
					if (lk_sweep) begin
						state_q   <= S_SWEEP;
						ptr_q     <= '0;
						rd_last_q <= 1'b0;
						pass2_q   <= 1'b0;
						proc_v_s1 <= 1'b0;
						ev_q      <= '0;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						hit_q       <= (op_q == REQ_GET) && rd_data.valid;
						payload_q   <= ((op_q == REQ_GET) && rd_data.valid) ?
							rd_data.payload : '0;
						ev_out_q    <= '0;
						if (lk_store && !rd_data.valid) begin
							count_q <= count_q + CNT_W'(1);
							occ_q   <= count_q + CNT_W'(1);
						end else begin
							occ_q <= count_q;
						end
						state_q <= S_IDLE;
					end
				end
				S_SWEEP: begin
					if (!over) begin
						proc_v_s1 <= 1'b0;
						state_q   <= S_COMMIT;
					end else begin
						if (free_slot) begin
							count_q <= count_q - CNT_W'(1);
							ev_q    <= ev_q + CNT_W'(1);
						end
						if (pass_end) begin
							proc_v_s1 <= 1'b0;
							if (pass2_q) begin
								state_q <= S_COMMIT;
							end else begin
								pass2_q   <= 1'b1;
								ptr_q     <= '0;
								rd_last_q <= 1'b0;
							end
						end else begin
							proc_v_s1   <= !rd_last_q;
							proc_idx_s1 <= ptr_q;
							if (!rd_last_q) begin
								ptr_q <= ptr_q + IDX_W'(1);
								if (ptr_q == LAST_IDX) begin
									rd_last_q <= 1'b1;
								end
							end
						end
					end
				end
				S_COMMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						hit_q       <= 1'b0;
						payload_q   <= '0;
						wipe_resp_q <= 1'b0;
						if (op_q == REQ_SET) begin
							count_q  <= count_q + CNT_W'(1);
							occ_q    <= count_q + CNT_W'(1);
							ev_out_q <= ev_q;
						end else begin
							occ_q    <= count_q;
							ev_out_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign payload_out = payload_q;
	assign occupancy   = occ_q;
	assign evicted     = ev_out_q;

endmodule

@@ sv/scsc_checker.sv @@
// ----------------------------------------------------------------------------
// scsc_checker
// Port-level checks of the score cache, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scsc_checker
	import scsc_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic                    hit,
	input logic [PAYLOAD_BITS-1:0] payload_out,
	input logic [CNT_W-1:0]        occupancy,
	input logic [CNT_W-1:0]        evicted
);

	logic [PAYLOAD_BITS+2*CNT_W:0] resp;

	assign resp = {hit, payload_out, occupancy, evicted};

	// A held result keeps its value until it is taken.
	`SCSC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(resp), "result changed while stalled")

	// A miss or any request other than a get reports a zero handle.
	`SCSC_NEVER(a_miss_zero, out_valid && !hit && (payload_out != '0), "handle on a miss")

	// A get that hits never reports a sweep.
	`SCSC_NEVER(a_hit_no_evict, out_valid && hit && (evicted != '0), "sweep on a hit")

	// The count of valid slots never exceeds the number of slots.
	`SCSC_NEVER(a_occ_range, out_valid && (occupancy > CNT_W'(SLOTS)), "occupancy out of range")

	// The block is not ready as reset is released, when its clearing pass starts.
	`SCSC_NEVER(a_reset_busy, $rose(arst_n) && in_ready, "ready during clearing pass")

endmodule

bind second_chance_score_cache scsc_checker u_scsc_checker (.*);

@@ bench/second_chance_score_cache_test.sv @@
// ----------------------------------------------------------------------------
// second_chance_score_cache_test
// Self-checking bench for the second-chance handle cache. A short table of
// directed requests and limit writes runs first. Randomized phases follow,
// each under its own occupancy limit. Every accepted request is run through
// a behavioral copy of the cache here, and each response is compared field by
// field with the oldest expected response.
// ----------------------------------------------------------------------------
module second_chance_score_cache_test;
	import scsc_pkg::*;

	// Request code that the block leaves without effect.
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	// A sweep can walk the slot memory twice, and a clear walks it once. Even
	// if every request paid for the longest of these plus the longest gap and
	// stall, about 950 requests stay well below this bound.
	localparam int CYCLE_LIMIT = 8_000_000;

	typedef struct packed {
		logic                    hit;
		logic [PAYLOAD_BITS-1:0] handle;
		logic [CNT_W-1:0]        occupancy;
		logic [CNT_W-1:0]        evicted;
	} response_t;

	typedef enum logic {ROW_REQUEST, ROW_LIMIT} row_kind_t;

	// One directed step. A limit row writes the limit field. A request row
	// carries a typed response only when the typed flag is set. Otherwise the
	// predictor supplies the response.
	typedef struct packed {
		row_kind_t               kind;
		logic [1:0]              req;
		logic [IDX_W-1:0]        idx;
		logic [PAYLOAD_BITS-1:0] data;
		logic [CNT_W-1:0]        limit;
		logic                    typed;
		response_t               want;
	} stim_row_t;

	// One randomized phase: the occupancy limit, the highest slot that most
	// requests aim at, the number of requests, and the request mix in percent.
	typedef struct packed {
		logic [CNT_W-1:0] limit;
		logic [IDX_W-1:0] top;
		logic [9:0]       count;
		logic [6:0]       get_pct;
		logic [6:0]       clear_pct;
	} phase_t;

	localparam int DIRECTED_ROWS = 28;
	localparam int PHASES = 9;

	// The first rows check the empty cache right after reset, the end slots,
	// the extremes of the handle, the unused request code, replacement and
	// clear. The later rows step the limit through 1, 0, all ones and 3. This
	// covers the small-limit case, where a sweep stops at a target of one,
	// and a sweep that must fall back to its second pass.
	stim_row_t directed [DIRECTED_ROWS] = '{
		'{ROW_REQUEST, REQ_GET,    10'd0,    32'h0,        11'd0, 1'b1,
			'{1'b0, 32'h0, 11'd0, 11'd0}},
		'{ROW_REQUEST, REQ_GET,    LAST_IDX, 32'h0,        11'd0, 1'b1,
			'{1'b0, 32'h0, 11'd0, 11'd0}},
		'{ROW_REQUEST, REQ_UNUSED, 10'd5,    32'hffffffff, 11'd0, 1'b1,
			'{1'b0, 32'h0, 11'd0, 11'd0}},
		'{ROW_REQUEST, REQ_SET,    10'd0,    32'h0,        11'd0, 1'b1,
			'{1'b0, 32'h0, 11'd1, 11'd0}},
		'{ROW_REQUEST, REQ_SET,    LAST_IDX, 32'hffffffff, 11'd0, 1'b1,
			'{1'b0, 32'h0, 11'd2, 11'd0}},
		'{ROW_REQUEST, REQ_GET,    10'd0,    32'h0,        11'd0, 1'b1,
			'{1'b1, 32'h0, 11'd2, 11'd0}},
		'{ROW_REQUEST, REQ_GET,    LAST_IDX, 32'h0,        11'd0, 1'b1,
			'{1'b1, 32'hffffffff, 11'd2, 11'd0}},
		'{ROW_REQUEST, REQ_SET,    10'd0,    32'ha5a55a5a, 11'd0, 1'b1,
			'{1'b0, 32'h0, 11'd2, 11'd0}},
		'{ROW_REQUEST, REQ_GET,    10'd0,    32'h0,        11'd0, 1'b1,
			'{1'b1, 32'ha5a55a5a, 11'd2, 11'd0}},
		'{ROW_REQUEST, REQ_UNUSED, 10'd0,    32'h0,        11'd0, 1'b1,
			'{1'b0, 32'h0, 11'd2, 11'd0}},
		'{ROW_REQUEST, REQ_SET,    LAST_IDX, 32'h0,        11'd0, 1'b0, '0},
		'{ROW_REQUEST, REQ_CLEAR,  10'd0,    32'h0,        11'd0, 1'b1,
			'{1'b0, 32'h0, 11'd0, 11'd0}},
		'{ROW_REQUEST, REQ_GET,    10'd0,    32'h0,        11'd0, 1'b1,
			'{1'b0, 32'h0, 11'd0, 11'd0}},
		'{ROW_LIMIT,   REQ_GET,    10'd0,    32'h0,        11'd1, 1'b0, '0},
		'{ROW_REQUEST, REQ_SET,    10'd3,    32'h1,        11'd0, 1'b1,
			'{1'b0, 32'h0, 11'd1, 11'd0}},
		'{ROW_REQUEST, REQ_SET,    10'd2,    32'h2,        11'd0, 1'b1,
			'{1'b0, 32'h0, 11'd2, 11'd0}},
		'{ROW_REQUEST, REQ_SET,    10'd7,    32'h3,        11'd0, 1'b0, '0},
		'{ROW_REQUEST, REQ_GET,    10'd3,    32'h0,        11'd0, 1'b0, '0},
		'{ROW_LIMIT,   REQ_GET,    10'd0,    32'h0,        11'd0, 1'b0, '0},
		'{ROW_REQUEST, REQ_SET,    10'd9,    32'h4,        11'd0, 1'b0, '0},
		'{ROW_REQUEST, REQ_GET,    10'd9,    32'h0,        11'd0, 1'b0, '0},
		'{ROW_LIMIT,   REQ_GET,    10'd0,    32'h0,        11'h7ff, 1'b0, '0},
		'{ROW_REQUEST, REQ_SET,    10'h155,  32'h55555555, 11'd0, 1'b0, '0},
		'{ROW_REQUEST, REQ_SET,    10'h2aa,  32'haaaaaaaa, 11'd0, 1'b0, '0},
		'{ROW_REQUEST, REQ_SET,    10'h040,  32'h12345678, 11'd0, 1'b0, '0},
		'{ROW_LIMIT,   REQ_GET,    10'd0,    32'h0,        11'd3, 1'b0, '0},
		'{ROW_REQUEST, REQ_SET,    10'h100,  32'h9abcdef0, 11'd0, 1'b0, '0},
		'{ROW_REQUEST, REQ_GET,    10'h155,  32'h0,        11'd0, 1'b0, '0}
	};

	// The first phase fills a few hundred slots under the reset limit. The
	// next one drops the limit to 5, so its first set on an empty slot evicts
	// almost all of them at once. The others but the last keep the working set
	// close to the limit, so gets hit and sweeps come often but stay short.
	phase_t plan [PHASES] = '{
		'{11'd1024, 10'd1023, 10'd300, 7'd30, 7'd0},
		'{11'd5,    10'd15,   10'd80,  7'd45, 7'd2},
		'{11'd0,    10'd7,    10'd40,  7'd45, 7'd3},
		'{11'd1,    10'd7,    10'd40,  7'd45, 7'd3},
		'{11'd2,    10'd7,    10'd40,  7'd45, 7'd3},
		'{11'd12,   10'd23,   10'd100, 7'd45, 7'd3},
		'{11'd40,   10'd63,   10'd120, 7'd40, 7'd2},
		'{11'd100,  10'd159,  10'd120, 7'd35, 7'd2},
		'{11'h7ff,  10'd1023, 10'd60,  7'd45, 7'd3}
	};

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [1:0]              req_type = REQ_GET;
	logic [IDX_W-1:0]        slot_index = '0;
	logic [PAYLOAD_BITS-1:0] payload_in = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic                    hit;
	logic [PAYLOAD_BITS-1:0] payload_out;
	logic [CNT_W-1:0]        occupancy;
	logic [CNT_W-1:0]        evicted;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CNT_W-1:0]        cfg_data = '0;

	// Behavioral copy of the cache contents and its limit.
	bit                      slot_live [SLOTS];
	bit                      slot_ref [SLOTS];
	logic [PAYLOAD_BITS-1:0] slot_data [SLOTS];
	int unsigned             live_count = 0;
	logic [CNT_W-1:0]        max_limit = MAX_RESET_V;

	response_t pending_responses [$];
	int        error_count = 0;
	int        cycle_count = 0;
	int        stall_left = 0;
	// While calm is set, neither side inserts gaps or stalls.
	bit        calm = 1'b0;

	always #4 clk = ~clk;

	second_chance_score_cache dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.slot_index (slot_index),
		.payload_in (payload_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hit        (hit),
		.payload_out(payload_out),
		.occupancy  (occupancy),
		.evicted    (evicted),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	// Applies one request to the copy of the cache and returns its response.
	// A set on an empty slot that would push the count past the limit first
	// sweeps the slots in ascending order. The first pass frees slots that
	// were not referenced and clears the referenced bit of every live slot it
	// passes. The second pass frees any slot. Both passes stop as soon as the
	// count is down to two thirds of the limit plus one.
	function automatic response_t predict_response(input logic [1:0] req,
			input logic [IDX_W-1:0] idx, input logic [PAYLOAD_BITS-1:0] data);
		response_t   r;
		int unsigned target;
		int unsigned freed;
		int          i;
		r = '0;
		freed = 0;
		target = (2 * int'(max_limit)) / 3 + 1;
		case (req)
			REQ_GET: begin
				// A get on an empty slot still marks it referenced.
				slot_ref[idx] = 1'b1;
				if (slot_live[idx]) begin
					r.hit = 1'b1;
					r.handle = slot_data[idx];
				end
			end
			REQ_SET: begin
				if (!slot_live[idx]) begin
					if (live_count + 1 > max_limit) begin
						for (i = 0; i < SLOTS && live_count > target; i++) begin
							if (slot_live[i]) begin
								if (!slot_ref[i]) begin
									slot_live[i] = 1'b0;
									live_count--;
									freed++;
								end
								slot_ref[i] = 1'b0;
							end
						end
						for (i = 0; i < SLOTS && live_count > target; i++) begin
							if (slot_live[i]) begin
								slot_live[i] = 1'b0;
								slot_ref[i] = 1'b0;
								live_count--;
								freed++;
							end
						end
					end
					live_count++;
					slot_live[idx] = 1'b1;
				end
				slot_data[idx] = data;
				slot_ref[idx] = 1'b1;
			end
			REQ_CLEAR: begin
				for (i = 0; i < SLOTS; i++) begin
					slot_live[i] = 1'b0;
					slot_ref[i] = 1'b0;
				end
				live_count = 0;
			end
			default: begin
				// The unused code leaves the cache untouched.
			end
		endcase
		r.occupancy = CNT_W'(live_count);
		r.evicted = CNT_W'(freed);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [PAYLOAD_BITS-1:0] want,
			input logic [PAYLOAD_BITS-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	// Response side. A response is taken at an edge where out_valid and
	// out_ready were both high. The values read here are those from before
	// the edge, so the order of events within the step does not matter. After
	// each response the receiver draws a stall, which it waits out with
	// out_ready low.
	always @(posedge clk) begin
		response_t want;
		int        next_stall;
		if (arst_n && out_valid && out_ready) begin
			if (pending_responses.size() == 0) begin
				$display("%0t: unexpected response: expected none, actual %0b %0h %0d %0d",
					$time, hit, payload_out, occupancy, evicted);
				error_count++;
			end else begin
				want = pending_responses.pop_front();
				check_field("hit", PAYLOAD_BITS'(want.hit), PAYLOAD_BITS'(hit));
				check_field("payload_out", want.handle, payload_out);
				check_field("occupancy", PAYLOAD_BITS'(want.occupancy),
					PAYLOAD_BITS'(occupancy));
				check_field("evicted", PAYLOAD_BITS'(want.evicted),
					PAYLOAD_BITS'(evicted));
			end
			next_stall = calm ? 0 : $urandom_range(0, 9);
			stall_left <= next_stall;
			out_ready <= (next_stall == 0);
		end else begin
			if (stall_left > 0)
				stall_left <= stall_left - 1;
			out_ready <= (stall_left <= 1);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** second_chance_score_cache: FAILED **");
			$finish;
		end
	end

	// Offers one request after a random gap and holds it until the block
	// takes it. It is always called at a rising edge. A request that follows
	// with no gap keeps in_valid high and only changes the request fields, so
	// in_valid never gets two assignments in one step. On acceptance the
	// response is predicted and queued. A row that carries a typed response
	// queues that one instead, but still updates the copy of the cache.
	task automatic issue_request(input logic [1:0] req, input logic [IDX_W-1:0] idx,
			input logic [PAYLOAD_BITS-1:0] data, input logic typed, input response_t want);
		int        gap;
		response_t predicted;
		gap = calm ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		slot_index <= idx;
		payload_in <= data;
		do @(posedge clk); while (!in_ready);
		predicted = predict_response(req, idx, data);
		pending_responses.insert(pending_responses.size(), typed ? want : predicted);
	endtask

	// The limit is written only once every outstanding response is back.
	// Every request produces a response, so the block is idle by then.
	task automatic write_limit(input logic [CNT_W-1:0] value);
		in_valid <= 1'b0;
		while (pending_responses.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		max_limit = value;
	endtask

	initial begin
		int               p;
		int               n;
		int               r;
		logic [1:0]       req;
		logic [IDX_W-1:0] idx;

		// Reset is held and then released at a rising edge. The block then
		// clears its memory with in_ready low, and the first request simply
		// waits for that to finish.
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < DIRECTED_ROWS; n++) begin
			if (directed[n].kind == ROW_LIMIT)
				write_limit(directed[n].limit);
			else
				issue_request(directed[n].req, directed[n].idx, directed[n].data,
					directed[n].typed, directed[n].want);
		end

		for (p = 0; p < PHASES; p++) begin
			write_limit(plan[p].limit);
			for (n = 0; n < plan[p].count; n++) begin
				// Now and then both sides run without gaps or stalls.
				if (n % 50 == 0)
					calm = ($urandom_range(0, 3) == 0);
				r = $urandom_range(0, 99);
				if (r < plan[p].get_pct)
					req = REQ_GET;
				else if (r < plan[p].get_pct + plan[p].clear_pct)
					req = REQ_CLEAR;
				else if (r < plan[p].get_pct + plan[p].clear_pct + 3)
					req = REQ_UNUSED;
				else
					req = REQ_SET;
				// Most requests stay inside the phase's working set, and the
				// rest can reach any slot.
				if ($urandom_range(0, 99) < 85)
					idx = IDX_W'($urandom_range(0, plan[p].top));
				else
					idx = IDX_W'($urandom_range(0, SLOTS - 1));
				issue_request(req, idx, $urandom, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (pending_responses.size() != 0) @(posedge clk);
		// A final wait catches any response that should not come.
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("** second_chance_score_cache: PASSED **");
		else
			$display("** second_chance_score_cache: FAILED **");
		$finish;
	end

endmodule
